[hdl/nca_pkg.sv]
// ============================================================================
// nca_pkg
// Types and constants shared by the nearest-center assignment block and its
// distance cells.
// ============================================================================
package nca_pkg;

    localparam int MAX_CENTERS_DEF = 8;
    localparam int VECTOR_DIMS_DEF = 16;

    localparam int VALUE_W   = 16;
    localparam int DIM_IDX_W = 4;
    localparam int LABEL_W   = 3;
    localparam int COUNT_W   = 4;
    localparam int DIST_W    = 40;
    localparam int SQ_W      = 32;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 4;

    typedef logic [LABEL_W-1:0]        label_t;
    typedef logic [DIST_W-1:0]         dist_t;
    typedef logic signed [VALUE_W-1:0] value_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTERS_IN_USE = 1'b0,
        REG_ONLY_DISTANCE  = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        OP_CENTER_WRITE = 1'b0,
        OP_SAMPLE       = 1'b1
    } op_t;

    typedef struct packed {
        logic                 operation;
        logic [2:0]           center_index;
        logic [DIM_IDX_W-1:0] dim_index;
        value_t               value;
        logic                 last;
        label_t               assigned_label;
    } in_item_t;

    typedef struct packed {
        label_t label;
        dist_t  distance;
    } out_item_t;

    // Control of the accumulate stage, shared by all cells.
    typedef struct packed {
        logic valid;
        logic add;
        logic last;
    } pipe_ctl_t;

    // Search mode, shared by all cells.
    typedef struct packed {
        logic               only;
        label_t             given;
        logic [COUNT_W-1:0] active;
    } mode_t;

    // Running best candidate handed from cell to cell.
    typedef struct packed {
        logic   tok;
        logic   have;
        label_t label;
        dist_t  distance;
    } best_t;

endpackage

[hdl/nca_cell.sv]
// ============================================================================
// nca_cell
// One center: holds its elements, accumulates the squared difference to the
// sample, and updates the running nearest candidate passed along the chain.
// ============================================================================
module nca_cell #(
    parameter int IDX   = 0,
    parameter int DEPTH = nca_pkg::VECTOR_DIMS_DEF,
    parameter int DIM_W = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic              rd_en,
    input  logic [DIM_W-1:0]  addr,
    input  nca_pkg::value_t   wr_data,
    input  nca_pkg::value_t   smp_value,
    input  nca_pkg::pipe_ctl_t ctl,
    input  nca_pkg::mode_t    mode,
    input  nca_pkg::best_t    best_in,
    output nca_pkg::best_t    best_out
);

    logic [nca_pkg::VALUE_W-1:0] mem [DEPTH];

    nca_pkg::value_t            center_reg;
    logic [nca_pkg::SQ_W-1:0]   sq_reg;
    logic [nca_pkg::SQ_W-1:0]   sq_next;
    nca_pkg::dist_t             acc_reg;
    nca_pkg::dist_t             acc_next;
    nca_pkg::dist_t             fin_reg;
    nca_pkg::dist_t             sum;
    logic [nca_pkg::DIST_W:0]   sum_wide;
    nca_pkg::best_t             best_reg;
    nca_pkg::best_t             best_next;
    logic signed [nca_pkg::VALUE_W:0] diff;
    logic [nca_pkg::VALUE_W-1:0]      mag;
    logic                       take;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
        if (rd_en)
        begin
            center_reg <= nca_pkg::value_t'(mem[addr]);
        end
    end

    always_comb
    begin
        diff    = {smp_value[nca_pkg::VALUE_W-1], smp_value}
                - {center_reg[nca_pkg::VALUE_W-1], center_reg};
        mag     = diff[nca_pkg::VALUE_W] ? nca_pkg::VALUE_W'(-diff)
                                         : diff[nca_pkg::VALUE_W-1:0];
        sq_next = nca_pkg::SQ_W'(mag) * nca_pkg::SQ_W'(mag);
    end

    always_ff @(posedge clk)
    begin
        sq_reg <= sq_next;
    end

    always_comb
    begin
        sum_wide = {1'b0, acc_reg} + (nca_pkg::DIST_W + 1)'(sq_reg);
        if (!ctl.add)
        begin
            sum = acc_reg;
        end
        else if (sum_wide[nca_pkg::DIST_W])
        begin
            sum = '1;
        end
        else
        begin
            sum = sum_wide[nca_pkg::DIST_W-1:0];
        end
        acc_next = acc_reg;
        if (ctl.valid)
        begin
            acc_next = ctl.last ? '0 : sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.valid && ctl.last)
        begin
            fin_reg <= sum;
        end
    end

    always_comb
    begin
        if (mode.only)
        begin
            take = (32'(mode.given) == IDX);
        end
        else
        begin
            take = (IDX < 32'(mode.active)) && (!best_in.have || fin_reg < best_in.distance);
        end
        best_next = best_in;
        if (best_in.tok && take)
        begin
            best_next.have     = 1'b1;
            best_next.label    = nca_pkg::label_t'(IDX);
            best_next.distance = fin_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg <= '0;
        end
        else
        begin
            best_reg <= best_next;
        end
    end

    assign best_out = best_reg;

endmodule

[hdl/nearest_center_assign.sv]
// ============================================================================
// nearest_center_assign
// Nearest-center search over squared Euclidean distance in fixed point.
// ============================================================================
// Center and sample elements are accepted one per cycle. Each center has a
// cell with its own element memory and 40-bit saturating accumulator, so a
// sample element is applied to all centers at once in a three-stage pipeline
// (memory read, square, accumulate). After the element marked last is
// accepted, the input stalls while the running minimum walks down the row of
// cells, one cell per cycle, and opens again once the result is taken. Ties go
// to the lower center index; in only-distance mode the cell of the assigned label is taken.
// Center memory holds no reset value and must be written before it is used.
module nearest_center_assign #(
    parameter int MAX_CENTERS = nca_pkg::MAX_CENTERS_DEF,
    parameter int VECTOR_DIMS = nca_pkg::VECTOR_DIMS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [nca_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [nca_pkg::CFG_DAT_W-1:0]   cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  nca_pkg::in_item_t               in_item,
    output logic                            out_valid,
    input  logic                            out_stall,
    output nca_pkg::out_item_t              out_item
);

    localparam int DIM_W = (VECTOR_DIMS > 1) ? $clog2(VECTOR_DIMS) : 1;
    localparam int EXT_W = (DIM_W > nca_pkg::DIM_IDX_W) ? DIM_W : nca_pkg::DIM_IDX_W;

    logic [nca_pkg::COUNT_W-1:0] centers_in_use_reg;
    logic                        only_distance_reg;
    logic                        busy_reg;
    logic                        busy_next;
    nca_pkg::label_t             given_reg;
    nca_pkg::value_t             value_reg;
    nca_pkg::pipe_ctl_t          p1_reg;
    nca_pkg::pipe_ctl_t          p2_reg;
    logic                        start_reg;
    logic                        out_valid_reg;
    nca_pkg::out_item_t          out_item_reg;

    logic                        in_acc;
    logic                        out_acc;
    logic                        dim_ok;
    logic                        center_ok;
    logic                        is_sample;
    logic [EXT_W-1:0]            dim_ext;
    logic [DIM_W-1:0]            addr;
    logic [nca_pkg::COUNT_W-1:0] active;
    nca_pkg::mode_t              mode;
    nca_pkg::best_t              chain [MAX_CENTERS+1];

    assign in_acc    = in_valid && !in_stall;
    assign out_acc   = out_valid_reg && !out_stall;
    assign in_stall  = busy_reg;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    assign is_sample = (in_item.operation == nca_pkg::OP_SAMPLE);
    assign dim_ok    = 32'(in_item.dim_index) < VECTOR_DIMS;
    assign center_ok = 32'(in_item.center_index) < MAX_CENTERS;
    assign dim_ext   = EXT_W'(in_item.dim_index);
    assign addr      = dim_ext[DIM_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            centers_in_use_reg <= nca_pkg::COUNT_W'(8);
            only_distance_reg  <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (nca_pkg::cfg_reg_t'(cfg_index))
                nca_pkg::REG_CENTERS_IN_USE: centers_in_use_reg <= cfg_data;
                nca_pkg::REG_ONLY_DISTANCE:  only_distance_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        priority if (centers_in_use_reg == '0)
        begin
            active = nca_pkg::COUNT_W'(1);
        end
        else if (32'(centers_in_use_reg) > MAX_CENTERS)
        begin
            active = nca_pkg::COUNT_W'(MAX_CENTERS);
        end
        else
        begin
            active = centers_in_use_reg;
        end
        mode.only   = only_distance_reg;
        mode.given  = given_reg;
        mode.active = active;
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (in_acc && is_sample && in_item.last)
        begin
            busy_next = 1'b1;
        end
        else if (out_acc)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            p1_reg        <= '0;
            p2_reg        <= '0;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg     <= busy_next;
            p1_reg.valid <= in_acc && is_sample;
            p1_reg.add   <= dim_ok;
            p1_reg.last  <= in_item.last;
            p2_reg       <= p1_reg;
            start_reg    <= p2_reg.valid && p2_reg.last;
            if (chain[MAX_CENTERS].tok)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_acc)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            value_reg <= in_item.value;
        end
        if (in_acc && is_sample && in_item.last)
        begin
            given_reg <= in_item.assigned_label;
        end
        if (chain[MAX_CENTERS].tok)
        begin
            out_item_reg.label    <= chain[MAX_CENTERS].label;
            out_item_reg.distance <= chain[MAX_CENTERS].distance;
        end
    end

    always_comb
    begin
        chain[0].tok      = start_reg;
        chain[0].have     = 1'b0;
        chain[0].label    = given_reg;
        chain[0].distance = '1;
    end

    for (genvar k = 0; k < MAX_CENTERS; k++)
    begin : g_cell
        logic wr_en;
        logic rd_en;

        assign wr_en = in_acc && !is_sample && center_ok && dim_ok
                    && (32'(in_item.center_index) == k);
        assign rd_en = in_acc && is_sample && dim_ok;

        nca_cell #(
            .IDX   (k),
            .DEPTH (VECTOR_DIMS),
            .DIM_W (DIM_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .wr_en     (wr_en),
            .rd_en     (rd_en),
            .addr      (addr),
            .wr_data   (in_item.value),
            .smp_value (value_reg),
            .ctl       (p2_reg),
            .mode      (mode),
            .best_in   (chain[k]),
            .best_out  (chain[k+1])
        );
    end

    a_out_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> busy_reg)
        else $error("result pending without a sample in progress");

    a_start_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start_reg |-> (busy_reg && !out_valid_reg))
        else $error("search started while idle or with a result pending");

    a_out_taken_clears: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc |=> (!out_valid_reg && !busy_reg))
        else $error("result repeated after it was taken");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $past(in_acc && is_sample && in_item.last) |-> busy_reg)
        else $error("input opened before the result was delivered");

endmodule
